/* design/joystick_cursor_with_patch_rects_defines.svh */
// assertion macros for the joystick cursor block
// needs aclk and aresetn in the scope of the module that asserts
`ifndef JOYSTICK_CURSOR_WITH_PATCH_RECTS_DEFINES_SVH
`define JOYSTICK_CURSOR_WITH_PATCH_RECTS_DEFINES_SVH

// same-cycle implication
`define JCUR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JCUR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/jcur_pkg.sv */
// shared constants, types and microcode rom for the joystick cursor block
// no dependencies
package jcur_pkg;

    localparam int CURSOR_SIDE   = 9;
    localparam int MAP_WIDTH     = 420;
    localparam int SCREEN_HEIGHT = 320;
    localparam int IMAGE_SIDE    = 2048;

    localparam int SAMPLE_W = 10;
    localparam int SPEED_W  = 6;
    localparam int CENTER_W = 10;
    localparam int DEAD_W   = 9;
    localparam int POS_W    = 9;
    localparam int IMG_W    = 12;
    localparam int SIZE_W   = 7;

    localparam int STICK_MAX = (1 << SAMPLE_W) - 1;
    localparam int HALF_SIDE = CURSOR_SIDE >> 1;
    localparam int ODD_PAD   = CURSOR_SIDE & 1;
    localparam int X_LO      = HALF_SIDE;
    localparam int X_HI      = MAP_WIDTH - HALF_SIDE - ODD_PAD;
    localparam int Y_LO      = HALF_SIDE;
    localparam int Y_HI      = SCREEN_HEIGHT - HALF_SIDE - ODD_PAD;
    localparam int MAP_OFS_X = (IMAGE_SIDE - MAP_WIDTH) >> 1;
    localparam int MAP_OFS_Y = (IMAGE_SIDE - SCREEN_HEIGHT) >> 1;

    localparam int TH_W      = SAMPLE_W + 1;
    localparam int PROD_W    = SAMPLE_W + SPEED_W;
    localparam int DIV_STEPS = SPEED_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
    localparam int STEP_W    = SPEED_W + 2;
    localparam int CRD_W     = POS_W + 2;
    localparam int DLT_W     = POS_W + 1;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_MIN_SPEED,
        REG_MAX_SPEED,
        REG_STICK_CENTER,
        REG_DEAD_ZONE
    } reg_idx_t;

    typedef struct packed {
        logic [SPEED_W-1:0]  min_speed;
        logic [SPEED_W-1:0]  max_speed;
        logic [CENTER_W-1:0] stick_center;
        logic [DEAD_W-1:0]   dead_zone;
    } cfg_t;

    typedef enum logic {AXIS_X, AXIS_Y} axis_t;

    typedef enum logic [1:0] {DIR_NONE, DIR_POS, DIR_NEG} dir_t;

    typedef enum logic [1:0] {EMIT_NONE, EMIT_H, EMIT_V, EMIT_STILL} emit_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DIV_RUN,
        COND_STILL,
        COND_DX_ZERO,
        COND_DY_ZERO
    } cond_t;

    typedef logic [3:0] upc_t;

    // microcode step addresses
    localparam upc_t UPC_IDLE       = 4'd0;
    localparam upc_t UPC_SETUP_X    = 4'd1;
    localparam upc_t UPC_DIV_X      = 4'd2;
    localparam upc_t UPC_SETUP_Y    = 4'd3;
    localparam upc_t UPC_DIV_Y      = 4'd4;
    localparam upc_t UPC_FINISH_Y   = 4'd5;
    localparam upc_t UPC_MOVE       = 4'd6;
    localparam upc_t UPC_CHECK      = 4'd7;
    localparam upc_t UPC_SKIP_H     = 4'd8;
    localparam upc_t UPC_EMIT_H     = 4'd9;
    localparam upc_t UPC_EMIT_V     = 4'd10;
    localparam upc_t UPC_EMIT_STILL = 4'd11;

    typedef struct packed {
        logic  accept;
        logic  setup;
        logic  finish;
        logic  move;
        emit_t emit;
        axis_t axis;
        cond_t cond;
        upc_t  target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic div_run;
        logic dx_zero;
        logic dy_zero;
    } stat_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_x;
        logic [POS_W-1:0]  cursor_y;
        logic              moved;
        logic [IMG_W-1:0]  image_col;
        logic [IMG_W-1:0]  image_row;
        logic [POS_W-1:0]  screen_col;
        logic [POS_W-1:0]  screen_row;
        logic [SIZE_W-1:0] patch_width;
        logic [SIZE_W-1:0] patch_height;
        logic              last;
    } res_t;

    // control store: one word per step, jump taken when cond holds
    function automatic ctrl_t ucode(input upc_t addr);
        ctrl_t w;
        w = '0;
        unique case (addr)
            UPC_IDLE: begin
                w.accept = 1'b1;
                w.cond   = COND_NO_INPUT;
                w.target = UPC_IDLE;
            end
            UPC_SETUP_X: begin
                w.setup = 1'b1;
                w.axis  = AXIS_X;
            end
            UPC_DIV_X: begin
                w.cond   = COND_DIV_RUN;
                w.target = UPC_DIV_X;
            end
            UPC_SETUP_Y: begin
                w.finish = 1'b1;
                w.setup  = 1'b1;
                w.axis   = AXIS_Y;
            end
            UPC_DIV_Y: begin
                w.cond   = COND_DIV_RUN;
                w.target = UPC_DIV_Y;
            end
            UPC_FINISH_Y: begin
                w.finish = 1'b1;
            end
            UPC_MOVE: begin
                w.move = 1'b1;
            end
            UPC_CHECK: begin
                w.cond   = COND_STILL;
                w.target = UPC_EMIT_STILL;
            end
            UPC_SKIP_H: begin
                w.cond   = COND_DX_ZERO;
                w.target = UPC_EMIT_V;
            end
            UPC_EMIT_H: begin
                w.emit   = EMIT_H;
                w.cond   = COND_DY_ZERO;
                w.target = UPC_IDLE;
            end
            UPC_EMIT_V: begin
                w.emit   = EMIT_V;
                w.cond   = COND_ALWAYS;
                w.target = UPC_IDLE;
            end
            UPC_EMIT_STILL: begin
                w.emit   = EMIT_STILL;
                w.cond   = COND_ALWAYS;
                w.target = UPC_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* design/jcur_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on jcur_pkg
module jcur_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [jcur_pkg::PROD_W-1:0]    num,
    input  logic [jcur_pkg::SAMPLE_W-1:0]  den,
    output logic [jcur_pkg::SPEED_W-1:0]   quot,
    output logic                           run
);
    import jcur_pkg::*;

    logic [PROD_W-1:0]  rem_reg, rem_next;
    logic [PROD_W-2:0]  dsh_reg, dsh_next;
    logic [SPEED_W-1:0] quot_reg, quot_next;
    logic [DCNT_W-1:0]  cnt_reg, cnt_next;
    logic               fits;

    assign fits = rem_reg >= {1'b0, dsh_reg};
    assign quot = quot_reg;
    // high until the final iteration is under way
    assign run  = cnt_reg > DCNT_W'(1);

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            rem_next  = num;
            dsh_next  = {den, {(SPEED_W-1){1'b0}}};
            quot_next = '0;
            cnt_next  = DCNT_W'(DIV_STEPS);
        end else if (cnt_reg != '0) begin
            if (fits) begin
                rem_next = rem_reg - {1'b0, dsh_reg};
            end
            quot_next = {quot_reg[SPEED_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

endmodule

/* design/jcur_seq.sv */
// microcode sequencer: step counter, control store and conditional jumps
// depends on jcur_pkg
module jcur_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  jcur_pkg::stat_t stat,
    input  logic            out_free,
    output jcur_pkg::ctrl_t ctrl
);
    import jcur_pkg::*;

    upc_t upc_reg, upc_next;
    logic cond_hit;
    logic stall;

    assign ctrl  = ucode(upc_reg);
    // an emit step waits for the output register
    assign stall = (ctrl.emit != EMIT_NONE) && !out_free;

    always_comb begin
        unique case (ctrl.cond)
            COND_NEVER:    cond_hit = 1'b0;
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_NO_INPUT: cond_hit = !stat.in_valid;
            COND_DIV_RUN:  cond_hit = stat.div_run;
            COND_STILL:    cond_hit = stat.dx_zero && stat.dy_zero;
            COND_DX_ZERO:  cond_hit = stat.dx_zero;
            COND_DY_ZERO:  cond_hit = stat.dy_zero;
            default:       cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        if (stall) begin
            upc_next = upc_reg;
        end else if (cond_hit) begin
            upc_next = ctrl.target;
        end else begin
            upc_next = upc_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UPC_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* design/jcur_dp.sv */
// datapath: axis speed mapping, cursor clamp, patch rectangles, output register
// depends on jcur_pkg and jcur_div
module jcur_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  jcur_pkg::ctrl_t                ctrl,
    input  jcur_pkg::cfg_t                 cfg,
    input  logic                           s_valid,
    input  logic [jcur_pkg::SAMPLE_W-1:0]  s_x_sample,
    input  logic [jcur_pkg::SAMPLE_W-1:0]  s_y_sample,
    input  logic                           m_ready,
    output jcur_pkg::stat_t                stat,
    output logic                           out_free,
    output logic                           m_valid,
    output jcur_pkg::res_t                 res
);
    import jcur_pkg::*;

    logic [SAMPLE_W-1:0]      xs_reg, ys_reg;
    logic [POS_W-1:0]         cur_col_reg, cur_col_next, cur_row_reg, cur_row_next;
    logic [POS_W-1:0]         old_col_reg, old_row_reg;
    axis_t                    axis_reg;
    dir_t                     dir_reg, dir_new;
    logic                     negq_reg, negq_new;
    logic [SPEED_W-1:0]       base_reg, base_new;
    logic signed [STEP_W-1:0] step_x_reg, step_y_reg, step_new;
    logic signed [DLT_W-1:0]  dx_reg, dy_reg, dx_new, dy_new;
    logic                     m_valid_reg, m_valid_next;
    res_t                     res_reg, res_next, res_new;

    // setup
    logic [SAMPLE_W-1:0] smp;
    logic [TH_W-1:0]     hi_th, lo_diff;
    logic [SAMPLE_W-1:0] lo_th, defl, den;
    logic [SPEED_W-1:0]  spd_mag;
    logic                fast_lt_slow;
    logic [PROD_W-1:0]   prod;
    logic [SPEED_W-1:0]  quot;
    logic                div_run;

    // finish
    logic signed [STEP_W-1:0] qv, qs, val;

    // move
    logic signed [CRD_W-1:0] nx_raw, ny_raw;
    logic [POS_W-1:0]        nx, ny;

    // emit
    logic [IMG_W-1:0]       ic_pos, ic_neg, ir_pos, ir_neg;
    logic [POS_W-1:0]       sc_pos, sc_neg, sr_pos, sr_neg;
    logic signed [DLT_W-1:0] dx_neg, dy_neg;
    logic                   emit_fire;

    // ---- axis setup: thresholds, branch, product for the divider
    always_comb begin
        smp          = (ctrl.axis == AXIS_Y) ? ys_reg : xs_reg;
        hi_th        = {1'b0, cfg.stick_center} + {2'b00, cfg.dead_zone};
        lo_diff      = {1'b0, cfg.stick_center} - {2'b00, cfg.dead_zone};
        lo_th        = lo_diff[TH_W-1] ? '0 : lo_diff[SAMPLE_W-1:0];
        fast_lt_slow = cfg.max_speed < cfg.min_speed;
        spd_mag      = fast_lt_slow ? (cfg.min_speed - cfg.max_speed)
                                    : (cfg.max_speed - cfg.min_speed);
        dir_new      = DIR_NONE;
        defl         = smp;
        den          = lo_th;
        negq_new     = 1'b0;
        base_new     = cfg.max_speed;
        // positive side only while the upper threshold is below full scale
        if (({1'b0, smp} > hi_th) && (hi_th < TH_W'(STICK_MAX))) begin
            dir_new  = DIR_POS;
            defl     = smp - hi_th[SAMPLE_W-1:0];
            den      = SAMPLE_W'(STICK_MAX) - hi_th[SAMPLE_W-1:0];
            negq_new = fast_lt_slow;
            base_new = cfg.min_speed;
        end else if (smp < lo_th) begin
            dir_new  = DIR_NEG;
            negq_new = !fast_lt_slow && (spd_mag != '0);
        end
        prod = PROD_W'(defl) * PROD_W'(spd_mag);
    end

    jcur_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.setup),
        .num     (prod),
        .den     (den),
        .quot    (quot),
        .run     (div_run)
    );

    // ---- finish: signed quotient plus base speed, sign by side
    always_comb begin
        qv  = {2'b00, quot};
        qs  = negq_reg ? -qv : qv;
        val = qs + {2'b00, base_reg};
        unique case (dir_reg)
            DIR_POS:  step_new = val;
            DIR_NEG:  step_new = -val;
            DIR_NONE: step_new = '0;
            default:  step_new = '0;
        endcase
    end

    // ---- move: x steps the other way, clamp to the inset map area
    always_comb begin
        nx_raw = $signed({2'b00, cur_col_reg})
               - {{(CRD_W-STEP_W){step_x_reg[STEP_W-1]}}, step_x_reg};
        ny_raw = $signed({2'b00, cur_row_reg})
               + {{(CRD_W-STEP_W){step_y_reg[STEP_W-1]}}, step_y_reg};
        if (nx_raw < $signed(CRD_W'(X_LO))) begin
            nx = POS_W'(X_LO);
        end else if (nx_raw > $signed(CRD_W'(X_HI))) begin
            nx = POS_W'(X_HI);
        end else begin
            nx = nx_raw[POS_W-1:0];
        end
        if (ny_raw < $signed(CRD_W'(Y_LO))) begin
            ny = POS_W'(Y_LO);
        end else if (ny_raw > $signed(CRD_W'(Y_HI))) begin
            ny = POS_W'(Y_HI);
        end else begin
            ny = ny_raw[POS_W-1:0];
        end
        dx_new = $signed({1'b0, nx}) - $signed({1'b0, cur_col_reg});
        dy_new = $signed({1'b0, ny}) - $signed({1'b0, cur_row_reg});
        cur_col_next = ctrl.move ? nx : cur_col_reg;
        cur_row_next = ctrl.move ? ny : cur_row_reg;
    end

    // ---- emit: patch origins, new position for leading edges
    always_comb begin
        ic_pos = IMG_W'(MAP_OFS_X) + {3'b000, cur_col_reg} + IMG_W'(HALF_SIDE);
        ic_neg = IMG_W'(MAP_OFS_X) + {3'b000, old_col_reg} - IMG_W'(HALF_SIDE);
        ir_pos = IMG_W'(MAP_OFS_Y) + {3'b000, cur_row_reg} + IMG_W'(HALF_SIDE);
        ir_neg = IMG_W'(MAP_OFS_Y) + {3'b000, old_row_reg} - IMG_W'(HALF_SIDE);
        sc_pos = cur_col_reg + POS_W'(HALF_SIDE);
        sc_neg = old_col_reg - POS_W'(HALF_SIDE);
        sr_pos = cur_row_reg + POS_W'(HALF_SIDE);
        sr_neg = old_row_reg - POS_W'(HALF_SIDE);
        dx_neg = -dx_reg;
        dy_neg = -dy_reg;

        res_new              = res_reg;
        res_new.cursor_x     = cur_col_reg;
        res_new.cursor_y     = cur_row_reg;
        res_new.moved        = 1'b1;
        res_new.image_col    = ic_neg;
        res_new.image_row    = ir_neg;
        res_new.screen_col   = sc_neg;
        res_new.screen_row   = sr_neg;
        res_new.patch_width  = SIZE_W'(CURSOR_SIDE);
        res_new.patch_height = SIZE_W'(CURSOR_SIDE);
        res_new.last         = 1'b1;
        unique case (ctrl.emit)
            EMIT_H: begin
                res_new.last = (dy_reg == '0);
                if (dx_reg[DLT_W-1]) begin
                    res_new.image_col   = ic_pos;
                    res_new.screen_col  = sc_pos;
                    res_new.patch_width = dx_neg[SIZE_W-1:0] + SIZE_W'(ODD_PAD);
                end else begin
                    res_new.patch_width = dx_reg[SIZE_W-1:0];
                end
            end
            EMIT_V: begin
                if (dy_reg[DLT_W-1]) begin
                    res_new.image_row    = ir_pos;
                    res_new.screen_row   = sr_pos;
                    res_new.patch_height = dy_neg[SIZE_W-1:0] + SIZE_W'(ODD_PAD);
                end else begin
                    res_new.patch_height = dy_reg[SIZE_W-1:0];
                end
            end
            EMIT_STILL: begin
                res_new.moved        = 1'b0;
                res_new.image_col    = '0;
                res_new.image_row    = '0;
                res_new.screen_col   = '0;
                res_new.screen_row   = '0;
                res_new.patch_width  = '0;
                res_new.patch_height = '0;
            end
            EMIT_NONE: begin
                res_new.last = 1'b1;
            end
        endcase
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = (ctrl.emit != EMIT_NONE) && out_free;

    always_comb begin
        res_next = emit_fire ? res_new : res_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cur_col_reg <= POS_W'(MAP_WIDTH >> 1);
            cur_row_reg <= POS_W'(SCREEN_HEIGHT >> 1);
            axis_reg    <= AXIS_X;
            dir_reg     <= DIR_NONE;
        end else begin
            m_valid_reg <= m_valid_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            if (ctrl.setup) begin
                axis_reg <= ctrl.axis;
                dir_reg  <= dir_new;
            end
        end
        res_reg <= res_next;
        if (ctrl.accept && s_valid) begin
            xs_reg <= s_x_sample;
            ys_reg <= s_y_sample;
        end
        if (ctrl.setup) begin
            negq_reg <= negq_new;
            base_reg <= base_new;
        end
        // finish reads the axis set up before this cycle
        if (ctrl.finish) begin
            if (axis_reg == AXIS_Y) begin
                step_y_reg <= step_new;
            end else begin
                step_x_reg <= step_new;
            end
        end
        if (ctrl.move) begin
            old_col_reg <= cur_col_reg;
            old_row_reg <= cur_row_reg;
            dx_reg      <= dx_new;
            dy_reg      <= dy_new;
        end
    end

    assign stat.in_valid = s_valid;
    assign stat.div_run  = div_run;
    assign stat.dx_zero  = (dx_reg == '0);
    assign stat.dy_zero  = (dy_reg == '0);
    assign m_valid       = m_valid_reg;
    assign res           = res_reg;

endmodule

/* design/joystick_cursor_with_patch_rects.sv */
// Joystick cursor with map-patch rectangles. Each transfer of one x/y sample pair moves the
// kept cursor and yields one or two result transfers (one with moved clear when the cursor
// stays put, otherwise one patch per moving axis, horizontal first, last set on the final
// one). Each item is run by the small microcode sequencer, which takes the two axes one
// after the other through a single restoring divider at one quotient bit per cycle, then
// moves the cursor and loads the results, each emit step waiting while the output register
// is still full. Results sit in an output register, so the next item is taken once the
// last result is loaded.
// Configuration goes through the APB port at byte addresses 0, 4, 8, 12.
`include "joystick_cursor_with_patch_rects_defines.svh"

module joystick_cursor_with_patch_rects (
    input  logic                           aclk,
    input  logic                           aresetn,
    // apb configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [jcur_pkg::PADDR_W-1:0]   paddr,
    input  logic [jcur_pkg::PDATA_W-1:0]   pwdata,
    output logic [jcur_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    // sample input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [jcur_pkg::SAMPLE_W-1:0]  s_x_sample,
    input  logic [jcur_pkg::SAMPLE_W-1:0]  s_y_sample,
    // result output
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [jcur_pkg::POS_W-1:0]     m_cursor_x,
    output logic [jcur_pkg::POS_W-1:0]     m_cursor_y,
    output logic                           m_moved,
    output logic [jcur_pkg::IMG_W-1:0]     m_image_col,
    output logic [jcur_pkg::IMG_W-1:0]     m_image_row,
    output logic [jcur_pkg::POS_W-1:0]     m_screen_col,
    output logic [jcur_pkg::POS_W-1:0]     m_screen_row,
    output logic [jcur_pkg::SIZE_W-1:0]    m_patch_width,
    output logic [jcur_pkg::SIZE_W-1:0]    m_patch_height,
    output logic                           m_last
);
    import jcur_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     cfg_wr;
    ctrl_t    ctrl;
    stat_t    stat;
    logic     out_free;
    res_t     res;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            unique case (reg_idx)
                REG_MIN_SPEED:    cfg_next.min_speed    = pwdata[SPEED_W-1:0];
                REG_MAX_SPEED:    cfg_next.max_speed    = pwdata[SPEED_W-1:0];
                REG_STICK_CENTER: cfg_next.stick_center = pwdata[CENTER_W-1:0];
                REG_DEAD_ZONE:    cfg_next.dead_zone    = pwdata[DEAD_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_SPEED:    prdata = PDATA_W'(cfg_reg.min_speed);
            REG_MAX_SPEED:    prdata = PDATA_W'(cfg_reg.max_speed);
            REG_STICK_CENTER: prdata = PDATA_W'(cfg_reg.stick_center);
            REG_DEAD_ZONE:    prdata = PDATA_W'(cfg_reg.dead_zone);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_speed    <= SPEED_W'(0);
            cfg_reg.max_speed    <= SPEED_W'(9);
            cfg_reg.stick_center <= CENTER_W'(512);
            cfg_reg.dead_zone    <= DEAD_W'(64);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    jcur_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (stat),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    jcur_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_x_sample (s_x_sample),
        .s_y_sample (s_y_sample),
        .m_ready    (m_ready),
        .stat       (stat),
        .out_free   (out_free),
        .m_valid    (m_valid),
        .res        (res)
    );

    assign s_ready        = ctrl.accept;
    assign m_cursor_x     = res.cursor_x;
    assign m_cursor_y     = res.cursor_y;
    assign m_moved        = res.moved;
    assign m_image_col    = res.image_col;
    assign m_image_row    = res.image_row;
    assign m_screen_col   = res.screen_col;
    assign m_screen_row   = res.screen_row;
    assign m_patch_width  = res.patch_width;
    assign m_patch_height = res.patch_height;
    assign m_last         = res.last;

    // cursor never leaves the inset map area
    `JCUR_ASSERT_NOW(a_cursor_in_map, m_valid, (m_cursor_x >= POS_W'(X_LO)) && (m_cursor_x <= POS_W'(X_HI)) && (m_cursor_y >= POS_W'(Y_LO)) && (m_cursor_y <= POS_W'(Y_HI)), "cursor outside map area")
    // a patch for a real move is never empty
    `JCUR_ASSERT_NOW(a_patch_nonempty, m_valid && m_moved, (m_patch_width != '0) && (m_patch_height != '0), "empty patch on move")
    // a still result closes its item
    `JCUR_ASSERT_NOW(a_still_is_last, m_valid && !m_moved, m_last, "still result without last")
    // one item at a time through the sequencer
    `JCUR_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "input reopened right after a transfer")

endmodule

/* tb/tb.sv */
// self-checking testbench for joystick_cursor_with_patch_rects
// depends on jcur_pkg and the block's rtl; a scoreboard class predicts cursor moves and patches
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jcur_pkg::*;

    localparam int STICK_FULL  = (1 << SAMPLE_W) - 1;
    localparam int SIDE_HALF   = CURSOR_SIDE / 2;
    localparam int SIDE_PAD    = CURSOR_SIDE % 2;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_TAIL  = 40;

    // predicts the result transfers of each sample pair and checks them in order
    class cursor_scoreboard;
        int slow, fast, center, dead;
        int col, row;
        int errors;
        res_t pending_patches[$];

        function new();
            slow   = 0;
            fast   = 9;
            center = 512;
            dead   = 64;
            col    = MAP_WIDTH / 2;
            row    = SCREEN_HEIGHT / 2;
            errors = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_MIN_SPEED:    slow   = int'(val[SPEED_W-1:0]);
                REG_MAX_SPEED:    fast   = int'(val[SPEED_W-1:0]);
                REG_STICK_CENTER: center = int'(val[CENTER_W-1:0]);
                REG_DEAD_ZONE:    dead   = int'(val[DEAD_W-1:0]);
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_patches.size();
        endfunction

        // signed cursor step for one axis, positive above center
        function int stick_step(int s);
            int hi_th, lo_th;
            hi_th = center + dead;
            lo_th = center - dead;
            if (lo_th < 0) lo_th = 0;
            if (s > hi_th && hi_th < STICK_FULL)
                return (s - hi_th) * (fast - slow) / (STICK_FULL - hi_th) + slow;
            if (s < lo_th)
                return -((s * (slow - fast)) / lo_th + fast);
            return 0;
        endfunction

        function void push_patch(bit mv, int icol, int irow, int scol, int srow,
                                 int w, int h, bit fin);
            res_t r;
            r              = '0;
            r.cursor_x     = col[POS_W-1:0];
            r.cursor_y     = row[POS_W-1:0];
            r.moved        = mv;
            r.image_col    = icol[IMG_W-1:0];
            r.image_row    = irow[IMG_W-1:0];
            r.screen_col   = scol[POS_W-1:0];
            r.screen_row   = srow[POS_W-1:0];
            r.patch_width  = w[SIZE_W-1:0];
            r.patch_height = h[SIZE_W-1:0];
            r.last         = fin;
            pending_patches.push_back(r);
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] xs, logic [SAMPLE_W-1:0] ys);
            int x0, y0, x, y, dx, dy, ofs_x, ofs_y;
            int icol_pos, icol_neg, irow_pos, irow_neg;
            int scol_pos, scol_neg, srow_pos, srow_neg;
            x0 = col;
            y0 = row;
            x  = x0 - stick_step(int'(xs));
            y  = y0 + stick_step(int'(ys));
            if (x < SIDE_HALF) x = SIDE_HALF;
            if (x > MAP_WIDTH - SIDE_HALF - SIDE_PAD) x = MAP_WIDTH - SIDE_HALF - SIDE_PAD;
            if (y < SIDE_HALF) y = SIDE_HALF;
            if (y > SCREEN_HEIGHT - SIDE_HALF - SIDE_PAD) y = SCREEN_HEIGHT - SIDE_HALF - SIDE_PAD;
            col = x;
            row = y;
            dx  = x - x0;
            dy  = y - y0;
            if (dx == 0 && dy == 0) begin
                push_patch(1'b0, 0, 0, 0, 0, 0, 0, 1'b1);
                return;
            end
            ofs_x    = (IMAGE_SIDE - MAP_WIDTH) / 2;
            ofs_y    = (IMAGE_SIDE - SCREEN_HEIGHT) / 2;
            icol_pos = ofs_x + x + SIDE_HALF;
            icol_neg = ofs_x + x0 - SIDE_HALF;
            irow_pos = ofs_y + y + SIDE_HALF;
            irow_neg = ofs_y + y0 - SIDE_HALF;
            scol_pos = x + SIDE_HALF;
            scol_neg = x0 - SIDE_HALF;
            srow_pos = y + SIDE_HALF;
            srow_neg = y0 - SIDE_HALF;
            // horizontal patch goes out before the vertical one
            if (dx < 0)
                push_patch(1'b1, icol_pos, irow_neg, scol_pos, srow_neg,
                           -dx + SIDE_PAD, CURSOR_SIDE, dy == 0);
            else if (dx > 0)
                push_patch(1'b1, icol_neg, irow_neg, scol_neg, srow_neg,
                           dx, CURSOR_SIDE, dy == 0);
            if (dy < 0)
                push_patch(1'b1, icol_neg, irow_pos, scol_neg, srow_pos,
                           CURSOR_SIDE, -dy + SIDE_PAD, 1'b1);
            else if (dy > 0)
                push_patch(1'b1, icol_neg, irow_neg, scol_neg, srow_neg,
                           CURSOR_SIDE, dy, 1'b1);
        endfunction

        function void check_field(string name, int unsigned want_v, int unsigned got_v);
            if (want_v != got_v) begin
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_patches.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            want = pending_patches.pop_front();
            check_field("cursor_x", 32'(want.cursor_x), 32'(got.cursor_x));
            check_field("cursor_y", 32'(want.cursor_y), 32'(got.cursor_y));
            check_field("moved", 32'(want.moved), 32'(got.moved));
            check_field("image_col", 32'(want.image_col), 32'(got.image_col));
            check_field("image_row", 32'(want.image_row), 32'(got.image_row));
            check_field("screen_col", 32'(want.screen_col), 32'(got.screen_col));
            check_field("screen_row", 32'(want.screen_row), 32'(got.screen_row));
            check_field("patch_width", 32'(want.patch_width), 32'(got.patch_width));
            check_field("patch_height", 32'(want.patch_height), 32'(got.patch_height));
            check_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  psel, penable, pwrite, pready;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata, prdata;
    logic                  s_valid, s_ready;
    logic [SAMPLE_W-1:0]   s_x_sample, s_y_sample;
    logic                  m_valid, m_ready;
    logic [POS_W-1:0]      m_cursor_x, m_cursor_y, m_screen_col, m_screen_row;
    logic                  m_moved, m_last;
    logic [IMG_W-1:0]      m_image_col, m_image_row;
    logic [SIZE_W-1:0]     m_patch_width, m_patch_height;

    cursor_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    joystick_cursor_with_patch_rects dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_x_sample     (s_x_sample),
        .s_y_sample     (s_y_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cursor_x     (m_cursor_x),
        .m_cursor_y     (m_cursor_y),
        .m_moved        (m_moved),
        .m_image_col    (m_image_col),
        .m_image_row    (m_image_row),
        .m_screen_col   (m_screen_col),
        .m_screen_row   (m_screen_row),
        .m_patch_width  (m_patch_width),
        .m_patch_height (m_patch_height),
        .m_last         (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side backpressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // transfer monitor and watchdog
    always @(posedge aclk) begin : monitor
        res_t got;
        bit   busy;
        if (aresetn) begin
            busy = 1'b0;
            if (m_valid && m_ready) begin
                got = '{m_cursor_x, m_cursor_y, m_moved, m_image_col, m_image_row,
                        m_screen_col, m_screen_row, m_patch_width, m_patch_height, m_last};
                sb.check_result(got);
                busy = 1'b1;
            end
            if (s_valid && s_ready) begin
                sb.note_sample(s_x_sample, s_y_sample);
                busy = 1'b1;
            end
            if (psel && penable && pwrite && pready) busy = 1'b1;
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("joystick_cursor_with_patch_rects regression: fail");
                $finish;
            end
        end
    end

    // all driving tasks start and end at a falling edge
    task automatic send(input int xs, input int ys);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_x_sample = SAMPLE_W'(xs);
        s_y_sample = SAMPLE_W'(ys);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input int unsigned val, input int width);
        logic [31:0] word;
        // junk above the register width must be dropped by the block
        word    = val | ($urandom << width);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = word;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, word);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic load_regs(input int slow, input int fast, input int ctr, input int dz);
        wait_drained();
        reg_write(REG_MIN_SPEED, slow, SPEED_W);
        reg_write(REG_MAX_SPEED, fast, SPEED_W);
        reg_write(REG_STICK_CENTER, ctr, CENTER_W);
        reg_write(REG_DEAD_ZONE, dz, DEAD_W);
    endtask

    // samples biased toward thresholds, rails and the dead band
    function automatic int rand_sample();
        int hi_th, lo_th, v;
        hi_th = sb.center + sb.dead;
        lo_th = sb.center - sb.dead;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom_range(STICK_FULL);
            4:          v = $urandom_range(1) ? STICK_FULL : 0;
            5:          v = hi_th + $urandom_range(6) - 3;
            6:          v = lo_th + $urandom_range(6) - 3;
            7:          v = sb.center + $urandom_range(8) - 4;
            default:    v = $urandom_range(1) ? STICK_FULL - $urandom_range(60)
                                              : $urandom_range(60);
        endcase
        if (v < 0) v = 0;
        if (v > STICK_FULL) v = STICK_FULL;
        return v;
    endfunction

    task automatic run_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (n) begin
            if ($urandom_range(199) == 0) wait_drained();
            send(rand_sample(), rand_sample());
        end
    endtask

    task automatic pick_idling(output int idle, output int stall);
        case ($urandom_range(3))
            0:       begin idle = 0;  stall = 0;  end
            1:       begin idle = 52; stall = 0;  end
            2:       begin idle = 0;  stall = 52; end
            default: begin idle = 30; stall = 30; end
        endcase
    endtask

    initial begin
        int idle, stall;
        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_valid    = 1'b0;
        s_x_sample = '0;
        s_y_sample = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset settings, rails, threshold edges, all directions
        send(512, 512);
        send(576, 576);
        send(577, 577);
        send(448, 448);
        send(447, 447);
        send(1023, 512);
        send(0, 512);
        send(512, 1023);
        send(512, 0);
        send(1023, 1023);
        send(0, 0);
        send(1023, 0);
        send(0, 1023);
        // full speed into the clamps on both sides
        load_regs(0, 63, 512, 64);
        repeat (5) send(1023, 1023);
        repeat (8) send(0, 0);

        load_regs(0, 63, 512, 64);
        run_phase(250, 0, 0);
        // speed falls with deflection, no dead band
        load_regs(63, 0, 512, 0);
        run_phase(250, 52, 0);
        // low threshold saturates at zero
        load_regs(5, 40, 100, 300);
        run_phase(250, 0, 52);
        // high threshold above full scale
        load_regs(1, 20, 900, 200);
        run_phase(250, 30, 30);
        load_regs(63, 63, 0, 511);
        run_phase(100, 0, 0);
        load_regs(0, 63, 1023, 0);
        run_phase(150, 30, 30);
        repeat (2) begin
            load_regs($urandom_range(63), $urandom_range(63), $urandom_range(1023),
                      $urandom_range(511));
            pick_idling(idle, stall);
            run_phase(200, idle, stall);
        end

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("joystick_cursor_with_patch_rects regression: pass");
        end else begin
            $display("joystick_cursor_with_patch_rects regression: fail");
        end
        $finish;
    end

endmodule
